/* sv/mco_pkg.sv */
package mco_pkg;

	localparam int RADIUS_BITS = 13;
	localparam int COORD_BITS  = 15;
	localparam int OFS_W       = RADIUS_BITS + 1;  // signed x / y offsets
	localparam int ERR_W       = RADIUS_BITS + 4;  // signed midpoint error
	localparam int PNT_W       = COORD_BITS + 1;   // signed output coordinate

	localparam int IN_FIELD_W  = 2 * COORD_BITS + RADIUS_BITS;
	localparam int IN_DATA_W   = ((IN_FIELD_W + 7) / 8) * 8;
	localparam int OUT_DATA_W  = 2 * PNT_W;

	localparam int POINTS      = 8;
	localparam int CNT_W       = $clog2(POINTS);
	localparam logic [CNT_W-1:0] LAST_POINT = CNT_W'(POINTS - 1);

	typedef enum logic {
		OP_START = 1'b0,
		OP_STEP  = 1'b1
	} op_t;

endpackage

/* sv/midpoint_circle_outline.sv */
// channel | dir | tdata (low bit up)                         | side band
// s_*     | in  | center_x[14:0] center_y[29:15] radius[42:30] | tuser = op, 0 start 1 step
// m_*     | out | point_x[15:0] point_y[31:16]                | tlast = final point of circle
//
// a start item gives no result
// a step item on a running circle gives eight points, one per clock while m_tready is high;
// a step item with no circle running gives none
// the next item is taken in the cycle the eighth point of the previous step leaves
// reset clears the circle state and the output burst; m_tready low holds the current point
module midpoint_circle_outline (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [mco_pkg::IN_DATA_W-1:0] s_tdata,   // center_x, center_y, radius, zero pad
	input  logic                          s_tuser,   // op
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [mco_pkg::OUT_DATA_W-1:0] m_tdata,  // point_x, point_y
	output logic                          m_tlast
);
	import mco_pkg::*;

	// circle state
	logic                           active_q;
	logic signed [COORD_BITS-1:0]   center_col_q, center_row_q;
	logic signed [OFS_W-1:0]        offset_a_q, offset_b_q;
	logic signed [ERR_W-1:0]        error_term_q;

	// snapshot of one step for the output burst
	logic                           busy_s1;
	logic [CNT_W-1:0]               cnt_s1;
	logic signed [COORD_BITS-1:0]   cx_s1, cy_s1;
	logic signed [OFS_W-1:0]        x_s1, y_s1;
	logic                           fin_s1;

	logic                           in_fire, beat_done, last_beat;
	op_t                            op;
	logic signed [COORD_BITS-1:0]   in_cx, in_cy;
	logic [RADIUS_BITS-1:0]         in_radius;

	// advance of the midpoint pair
	logic signed [OFS_W-1:0]        y_inc, y_next, x_dec, x_next;
	logic signed [ERR_W-1:0]        err_mid, err_next;
	logic                           grow_y, shrink_x, fin_next;

	assign op        = op_t'(s_tuser);
	assign in_cx     = s_tdata[COORD_BITS-1:0];
	assign in_cy     = s_tdata[2*COORD_BITS-1:COORD_BITS];
	assign in_radius = s_tdata[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS];

	assign beat_done = m_tvalid && m_tready;
	assign last_beat = beat_done && (cnt_s1 == LAST_POINT);
	// the next item is let in in the same cycle the last point of the burst leaves
	assign s_tready  = !busy_s1 || last_beat;
	assign in_fire   = s_tvalid && s_tready;

	always_comb begin
		// first check: error <= 0 grows y
		grow_y   = error_term_q[ERR_W-1] || (error_term_q == '0);
		y_inc    = offset_b_q + OFS_W'(1);
		y_next   = grow_y ? y_inc : offset_b_q;
		err_mid  = grow_y ? error_term_q + ERR_W'({y_inc, 1'b1})
		                  : error_term_q;
		// second check on the updated error: error > 0 shrinks x
		shrink_x = !err_mid[ERR_W-1] && (err_mid != '0);
		x_dec    = offset_a_q - OFS_W'(1);
		x_next   = shrink_x ? x_dec : offset_a_q;
		err_next = shrink_x ? err_mid - {{(ERR_W-OFS_W-1){x_dec[OFS_W-1]}}, x_dec, 1'b1}
		                    : err_mid;
		fin_next = x_next < y_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			center_col_q <= '0;
			center_row_q <= '0;
			offset_a_q   <= '0;
			offset_b_q   <= '0;
			error_term_q <= '0;
		end else if (in_fire) begin
			if (op == OP_START) begin
				active_q     <= 1'b1;
				center_col_q <= in_cx;
				center_row_q <= in_cy;
				offset_a_q   <= OFS_W'(in_radius);
				offset_b_q   <= '0;
				error_term_q <= '0;
			end else if (active_q) begin
				active_q     <= !fin_next;
				offset_a_q   <= x_next;
				offset_b_q   <= y_next;
				error_term_q <= err_next;
			end
		end
	end

	// burst control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			cnt_s1  <= '0;
		end else if (in_fire && op == OP_STEP && active_q) begin
			busy_s1 <= 1'b1;
			cnt_s1  <= '0;
		end else if (last_beat) begin
			busy_s1 <= 1'b0;
			cnt_s1  <= '0;
		end else if (beat_done) begin
			cnt_s1  <= cnt_s1 + CNT_W'(1);
		end
	end

	// snapshot payload, the pre-advance pair
	always_ff @(posedge clk) begin
		if (in_fire && op == OP_STEP && active_q) begin
			cx_s1  <= center_col_q;
			cy_s1  <= center_row_q;
			x_s1   <= offset_a_q;
			y_s1   <= offset_b_q;
			fin_s1 <= fin_next;
		end
	end

	// octant order: (+x,+y) (+y,+x) (-y,+x) (-x,+y) (-x,-y) (-y,-x) (+y,-x) (+x,-y)
	logic                    swap, neg_x, neg_y;
	logic signed [PNT_W-1:0] cx_w, cy_w, dx_w, dy_w, px, py;

	always_comb begin
		swap  = cnt_s1[0] ^ cnt_s1[1];
		neg_x = cnt_s1[1] ^ cnt_s1[2];
		neg_y = cnt_s1[2];
		cx_w  = PNT_W'(cx_s1);
		cy_w  = PNT_W'(cy_s1);
		dx_w  = swap ? PNT_W'(y_s1) : PNT_W'(x_s1);
		dy_w  = swap ? PNT_W'(x_s1) : PNT_W'(y_s1);
		px    = neg_x ? cx_w - dx_w : cx_w + dx_w;
		py    = neg_y ? cy_w - dy_w : cy_w + dy_w;
	end

	assign m_tvalid = busy_s1;
	assign m_tdata  = {py, px};
	assign m_tlast  = fin_s1 && (cnt_s1 == LAST_POINT);

endmodule

/* sv/mco_checker.sv */
module mco_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [mco_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic                           m_tlast
);
	import mco_pkg::*;

	logic in_fire, out_fire;
	assign in_fire  = s_tvalid && s_tready;
	assign out_fire = m_tvalid && m_tready;

	// a stalled point holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled point changed");

	// input is only held back while points are pending
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no point pending");

	// the closing point of a circle ends the burst unless a new item came in
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && m_tlast && !in_fire |=> !m_tvalid)
		else $error("points continue after final point");

	// a start item gives no point
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (s_tuser == OP_START) && !m_tvalid |=> !m_tvalid)
		else $error("start item produced a point");

endmodule

bind midpoint_circle_outline mco_checker u_mco_checker (.*);

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

	import mco_pkg::*;

	typedef logic [COORD_BITS-1:0]  coord_t;
	typedef logic [RADIUS_BITS-1:0] radius_t;

	// one outline pixel as it should leave the master side
	typedef struct {
		logic [PNT_W-1:0] px;
		logic [PNT_W-1:0] py;
		logic             last;
	} outline_point_t;

	localparam int WATCHDOG_LIMIT = 5000;   // cycles with no item moving on either side
	localparam int TAIL_CYCLES    = 32;     // a full eight-point burst plus margin
	localparam int PRINT_CAP      = 40;     // mismatch lines printed before going quiet

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;     // center_x, center_y, radius, zero pad
	logic                  s_tuser = OP_START; // op
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;          // point_x, point_y
	logic                  m_tlast;

	// idling knobs, percent of cycles
	int src_idle_pct = 0;
	int sink_stall_pct = 0;

	// circle tracker: mirrors the block's own circle state
	bit circle_on = 1'b0;
	int ctr_col = 0;
	int ctr_row = 0;
	int off_x = 0;
	int off_y = 0;
	int mid_err = 0;

	outline_point_t expected_points[$];

	int mismatches = 0;
	int effective_items = 0;
	int idle_steps = 0;
	int circles_started = 0;
	int circles_finished = 0;
	int points_checked = 0;

	midpoint_circle_outline DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	task automatic report_mismatch(input string what, input longint want, input longint got);
		if (mismatches < PRINT_CAP)
			$display("[%0t] mismatch: %s, expected 0x%0h, got 0x%0h", $realtime, what, want, got);
		mismatches++;
	endtask

	function automatic void push_point(input int px, input int py, input bit last);
		outline_point_t p;
		p.px = PNT_W'(px);
		p.py = PNT_W'(py);
		p.last = last;
		expected_points = {expected_points, p};
	endfunction

	// midpoint circle step: emit eight mirrored points of the current (x, y), then
	// move y up once if the error is not positive, and x in once if it then is
	function automatic void advance_outline(input op_t op, input coord_t cx, input coord_t cy,
			input radius_t r);
		int x;
		int y;
		bit fin;
		if (op == OP_START) begin
			// a start drops any running circle
			ctr_col = $signed(cx);
			ctr_row = $signed(cy);
			off_x = r;
			off_y = 0;
			mid_err = 0;
			circle_on = 1'b1;
			effective_items++;
			circles_started++;
			return;
		end
		if (!circle_on) begin
			idle_steps++;
			return;
		end
		effective_items++;
		x = off_x;
		y = off_y;
		if (mid_err <= 0) begin
			off_y++;
			mid_err += 2 * off_y + 1;
		end
		// the second test sees the error already updated above
		if (mid_err > 0) begin
			off_x--;
			mid_err -= 2 * off_x + 1;
		end
		fin = (off_x < off_y);
		if (fin) begin
			circle_on = 1'b0;
			circles_finished++;
		end
		push_point(ctr_col + x, ctr_row + y, 1'b0);
		push_point(ctr_col + y, ctr_row + x, 1'b0);
		push_point(ctr_col - y, ctr_row + x, 1'b0);
		push_point(ctr_col - x, ctr_row + y, 1'b0);
		push_point(ctr_col - x, ctr_row - y, 1'b0);
		push_point(ctr_col - y, ctr_row - x, 1'b0);
		push_point(ctr_col + y, ctr_row - x, 1'b0);
		push_point(ctr_col + x, ctr_row - y, fin);
	endfunction

	// one item on the slave side; valid stays up across back-to-back items
	task automatic send_item(input op_t op, input coord_t cx, input coord_t cy, input radius_t r);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= IN_DATA_W'({r, cy, cx});
		do
			@(posedge clk);
		while (!s_tready);
		advance_outline(op, cx, cy, r);
	endtask

	task automatic send_step_random();
		send_item(OP_STEP, coord_t'($urandom), coord_t'($urandom), radius_t'($urandom));
	endtask

	// result checker: each point against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_points.size() == 0) begin
				report_mismatch("point with nothing outstanding", 0, {m_tlast, m_tdata});
			end else begin
				if (m_tdata[PNT_W-1:0] !== expected_points[0].px)
					report_mismatch("point_x", expected_points[0].px, m_tdata[PNT_W-1:0]);
				if (m_tdata[2*PNT_W-1:PNT_W] !== expected_points[0].py)
					report_mismatch("point_y", expected_points[0].py, m_tdata[2*PNT_W-1:PNT_W]);
				if (m_tlast !== expected_points[0].last)
					report_mismatch("last", expected_points[0].last, m_tlast);
				void'(expected_points.pop_front());
				points_checked++;
			end
		end
	end

	// hang detection
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[%0t] watchdog: no item moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	// a step with no circle loaded must give nothing
	task automatic test_step_while_idle();
		send_item(OP_STEP, '1, '1, '1);
	endtask

	// zero radius: center repeated eight times, the eighth marked, then idle again
	task automatic test_radius_zero();
		send_item(OP_START, coord_t'(0), coord_t'(-1), radius_t'(0));
		send_item(OP_STEP, '0, '0, '0);
		send_item(OP_STEP, '1, '1, '1);
	endtask

	// radius one at the corner of the coordinate range
	task automatic test_radius_one();
		send_item(OP_START, coord_t'(16383), coord_t'(-16384), radius_t'(1));
		send_step_random();
		send_step_random();
	endtask

	// largest radius at the extremes of the center, restarted while running, then a small one
	task automatic test_extremes_and_restart();
		send_item(OP_START, coord_t'(-16384), coord_t'(16383), radius_t'(8191));
		repeat (4) send_step_random();
		send_item(OP_START, coord_t'(16383), coord_t'(-16384), radius_t'(8191));
		repeat (4) send_item(OP_STEP, '1, '1, '1);
		send_item(OP_START, coord_t'(-16384), coord_t'(-16384), radius_t'(8191));
		repeat (2) send_step_random();
		send_item(OP_START, coord_t'(16383), coord_t'(16383), radius_t'(2));
		repeat (2) send_step_random();
	endtask

	// mostly whole circles with random centers, plus early restarts and stray steps
	task automatic test_random_circles(input int src_idle, input int sink_stall, input int n_items);
		int goal;
		int cap;
		int steps;
		int pick;
		radius_t r;
		src_idle_pct = src_idle;
		sink_stall_pct = sink_stall;
		goal = effective_items + n_items;
		while (effective_items < goal) begin
			pick = $urandom_range(99);
			if (pick < 6) begin
				send_step_random();
			end else begin
				pick = $urandom_range(99);
				if (pick < 75)
					r = radius_t'($urandom_range(24));
				else if (pick < 93)
					r = radius_t'($urandom_range(80, 25));
				else
					r = radius_t'($urandom_range(8191, 81));
				// big circles are only walked partway, then dropped by the next start
				cap = (r > 80) ? $urandom_range(30, 1) : 1000000;
				if ($urandom_range(9) == 0)
					cap = $urandom_range(3, 1);
				send_item(OP_START, coord_t'($urandom), coord_t'($urandom), r);
				steps = 0;
				while (circle_on && steps < cap) begin
					send_step_random();
					steps++;
				end
				if ($urandom_range(4) == 0)
					send_step_random();
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_step_while_idle();
		test_radius_zero();
		test_radius_one();
		test_extremes_and_restart();

		test_random_circles(0, 0, 110);
		test_random_circles(65, 0, 110);
		test_random_circles(0, 65, 110);
		test_random_circles(34, 34, 110);

		s_tvalid <= 1'b0;
		while (expected_points.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (expected_points.size() != 0)
			report_mismatch("points never delivered", expected_points.size(), 0);

		$display("covered %0d circles (%0d walked to the end), %0d points checked",
			circles_started, circles_finished, points_checked);
		$display("%0d steps sent with no circle running, %0d mismatches",
			idle_steps, mismatches);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* sim.f */
sv/mco_pkg.sv
sv/midpoint_circle_outline.sv
sv/mco_checker.sv
sim/tb_top.sv
